FILE: rtl/core/double_couple_moment_rate_core_assert.svh
// Assertion macros for the double-couple moment-rate core checker.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef DOUBLE_COUPLE_MOMENT_RATE_CORE_ASSERT_SVH
`define DOUBLE_COUPLE_MOMENT_RATE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DCMR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DCMR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/dcmr_pkg.sv
// Shared types and constants for the double-couple moment-rate core.
// No dependencies; imported by every module of the core.
`default_nettype none

package dcmr_pkg;

  localparam int NUM_ANG = 5;
  localparam int ANG_S   = 0;
  localparam int ANG_S2  = 1;
  localparam int ANG_D   = 2;
  localparam int ANG_D2  = 3;
  localparam int ANG_R   = 4;

  localparam int NUM_SLOT = 6;
  localparam int SLOT_XX  = 0;
  localparam int SLOT_YY  = 1;
  localparam int SLOT_ZZ  = 2;
  localparam int SLOT_XY  = 3;
  localparam int SLOT_XZ  = 4;
  localparam int SLOT_YZ  = 5;

  typedef logic [31:0]        phase_t;
  typedef logic signed [31:0] q30_t;
  typedef logic signed [33:0] term_t;

  typedef struct packed {
    logic signed [63:0] ar;
    logic               last;
  } dcmr_side_t;

  typedef struct packed {
    logic signed [63:0] m_xx;
    logic signed [63:0] m_yy;
    logic signed [63:0] m_zz;
    logic signed [63:0] m_xy;
    logic signed [63:0] m_xz;
    logic signed [63:0] m_yz;
    logic               last;
    logic               sat;
  } dcmr_beat_t;

endpackage

`default_nettype wire

FILE: rtl/core/dcmr_phase.sv
// Angle to phase conversion (three stages) plus area times rate product.
// Depends on dcmr_pkg.
`default_nettype none

module dcmr_phase (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic signed [25:0]       strike_angle,
  input  logic signed [25:0]       dip_angle,
  input  logic signed [25:0]       rake_angle,
  input  logic [31:0]              patch_area,
  input  logic signed [31:0]       slip_rate,
  input  logic                     last_item,
  input  logic                     rake_in_degrees,
  output logic                     out_valid,
  output dcmr_pkg::phase_t         phase [dcmr_pkg::NUM_ANG],
  output dcmr_pkg::dcmr_side_t     side
);
  import dcmr_pkg::*;

  localparam int NUM_DEG = 3;
  localparam int DEG_S   = 0;
  localparam int DEG_D   = 1;
  localparam int DEG_R   = 2;

  localparam logic [26:0] DEG_BIAS  = 27'd47185920;
  localparam logic [27:0] RECIP_45  = 28'd190887436;
  localparam logic [26:0] DIV_45    = 27'd45;
  localparam logic [23:0] RAD_LO    = 24'hDB9391;
  localparam logic [21:0] RAD_HI    = 22'h28BE60;
  localparam logic [63:0] RAD_ROUND = 64'h0000_0000_8000_0000;

  function automatic logic [12:0] deg_frac(input logic [5:0] r);
    logic [12:0] base;
    base = {7'd0, r} * 13'd182;
    if (r >= 6'd34) begin
      return base + 13'd2;
    end else if (r >= 6'd12) begin
      return base + 13'd1;
    end
    return base;
  endfunction

  logic signed [25:0] deg_in     [NUM_DEG];
  logic [26:0]        biased     [NUM_DEG];
  logic [54:0]        recip_prod [NUM_DEG];
  logic signed [50:0] rad_lo_prod;
  logic signed [48:0] rad_hi_prod;
  logic signed [64:0] ar_full;

  logic               v1;
  logic [26:0]        bias1 [NUM_DEG];
  logic [54:0]        prod1 [NUM_DEG];
  logic signed [50:0] rlo1;
  logic signed [48:0] rhi1;
  dcmr_side_t         side1;

  logic [21:0]        quot     [NUM_DEG];
  logic [26:0]        rem_full [NUM_DEG];
  logic [63:0]        rad_sum;

  logic               v2;
  logic [21:0]        quot2 [NUM_DEG];
  logic [5:0]         rem2  [NUM_DEG];
  phase_t             radph2;
  dcmr_side_t         side2;

  phase_t             deg_ph [NUM_DEG];
  phase_t             rake_ph;

  assign deg_in[DEG_S] = strike_angle;
  assign deg_in[DEG_D] = dip_angle;
  assign deg_in[DEG_R] = rake_angle;

  always_comb begin
    for (int k = 0; k < NUM_DEG; k++) begin
      biased[k]     = {deg_in[k][25], deg_in[k]} + DEG_BIAS;
      recip_prod[k] = {28'd0, biased[k]} * {27'd0, RECIP_45};
    end
  end

  assign rad_lo_prod = rake_angle * $signed({1'b0, RAD_LO});
  assign rad_hi_prod = rake_angle * $signed({1'b0, RAD_HI});
  assign ar_full     = $signed({1'b0, patch_area}) * slip_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bias1      <= biased;
      prod1      <= recip_prod;
      rlo1       <= rad_lo_prod;
      rhi1       <= rad_hi_prod;
      side1.ar   <= ar_full[63:0];
      side1.last <= last_item;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_DEG; k++) begin
      quot[k]     = prod1[k][54:33];
      rem_full[k] = bias1[k] - ({5'd0, quot[k]} * DIV_45);
    end
    rad_sum = {{13{rlo1[50]}}, rlo1} + {rhi1[39:0], 24'd0} + RAD_ROUND;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NUM_DEG; k++) begin
        quot2[k] <= quot[k];
        rem2[k]  <= rem_full[k][5:0];
      end
      radph2 <= rad_sum[63:32];
      side2  <= side1;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_DEG; k++) begin
      deg_ph[k] = {quot2[k][18:0], 13'd0} + {19'd0, deg_frac(rem2[k])};
    end
    rake_ph = rake_in_degrees ? deg_ph[DEG_R] : radph2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      phase[ANG_S]  <= deg_ph[DEG_S];
      phase[ANG_S2] <= {deg_ph[DEG_S][30:0], 1'b0};
      phase[ANG_D]  <= deg_ph[DEG_D];
      phase[ANG_D2] <= {deg_ph[DEG_D][30:0], 1'b0};
      phase[ANG_R]  <= rake_ph;
      side          <= side2;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dcmr_cordic.sv
// Pipelined rotation-mode CORDIC, one iteration per stage, five angle lanes.
// Depends on dcmr_pkg.
`default_nettype none

module dcmr_cordic (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  dcmr_pkg::phase_t     phase [dcmr_pkg::NUM_ANG],
  input  dcmr_pkg::dcmr_side_t side_in,
  output logic                 out_valid,
  output dcmr_pkg::q30_t       sin_out [dcmr_pkg::NUM_ANG],
  output dcmr_pkg::q30_t       cos_out [dcmr_pkg::NUM_ANG],
  output dcmr_pkg::dcmr_side_t side_out
);
  import dcmr_pkg::*;

  localparam int STEPS = 30;
  localparam logic signed [32:0] GAIN = 33'sh0_26DD_3B6A;
  localparam logic [31:0] QUARTER = 32'h4000_0000;
  localparam logic [31:0] HALF    = 32'h8000_0000;
  localparam logic [29:0] ATAN_TURN [STEPS] = '{
    30'h20000000, 30'h12E4051D, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
    30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2E,
    30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2F9,
    30'h0000517C, 30'h000028BE, 30'h0000145F, 30'h00000A2F, 30'h00000517,
    30'h0000028B, 30'h00000145, 30'h000000A2, 30'h00000051, 30'h00000028,
    30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000002, 30'h00000001
  };

  logic signed [32:0] rx   [STEPS+1][NUM_ANG];
  logic signed [32:0] ry   [STEPS+1][NUM_ANG];
  logic signed [32:0] rz   [STEPS+1][NUM_ANG];
  logic               flip [STEPS+1][NUM_ANG];
  logic               vld  [STEPS+1];
  dcmr_side_t         side_st [STEPS+1];

  phase_t             quarter_sum [NUM_ANG];
  phase_t             folded      [NUM_ANG];
  logic signed [32:0] neg_x [NUM_ANG];
  logic signed [32:0] neg_y [NUM_ANG];

  // Fold into [-1/4, 1/4) turn; a half-turn fold negates both outputs.
  always_comb begin
    for (int k = 0; k < NUM_ANG; k++) begin
      quarter_sum[k] = phase[k] + QUARTER;
      folded[k]      = quarter_sum[k][31] ? phase[k] + HALF : phase[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NUM_ANG; k++) begin
        rx[0][k]   <= GAIN;
        ry[0][k]   <= '0;
        rz[0][k]   <= {folded[k][31], folded[k]};
        flip[0][k] <= quarter_sum[k][31];
      end
      side_st[0] <= side_in;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [32:0] nx [NUM_ANG];
    logic signed [32:0] ny [NUM_ANG];
    logic signed [32:0] nz [NUM_ANG];

    always_comb begin
      for (int k = 0; k < NUM_ANG; k++) begin
        if (!rz[i][k][32]) begin
          nx[k] = rx[i][k] - (ry[i][k] >>> i);
          ny[k] = ry[i][k] + (rx[i][k] >>> i);
          nz[k] = rz[i][k] - $signed({3'd0, ATAN_TURN[i]});
        end else begin
          nx[k] = rx[i][k] + (ry[i][k] >>> i);
          ny[k] = ry[i][k] - (rx[i][k] >>> i);
          nz[k] = rz[i][k] + $signed({3'd0, ATAN_TURN[i]});
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (adv) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rx[i+1]      <= nx;
        ry[i+1]      <= ny;
        rz[i+1]      <= nz;
        flip[i+1]    <= flip[i];
        side_st[i+1] <= side_st[i];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_ANG; k++) begin
      neg_x[k] = -rx[STEPS][k];
      neg_y[k] = -ry[STEPS][k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NUM_ANG; k++) begin
        cos_out[k] <= flip[STEPS][k] ? neg_x[k][31:0] : rx[STEPS][k][31:0];
        sin_out[k] <= flip[STEPS][k] ? neg_y[k][31:0] : ry[STEPS][k][31:0];
      end
      side_out <= side_st[STEPS];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dcmr_terms.sv
// Double-couple term products in Q30 over four stages, in output slot order.
// Depends on dcmr_pkg.
`default_nettype none

module dcmr_terms (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  dcmr_pkg::q30_t       sin_in [dcmr_pkg::NUM_ANG],
  input  dcmr_pkg::q30_t       cos_in [dcmr_pkg::NUM_ANG],
  input  dcmr_pkg::dcmr_side_t side_in,
  output logic                 out_valid,
  output dcmr_pkg::term_t      term [dcmr_pkg::NUM_SLOT],
  output dcmr_pkg::dcmr_side_t side_out
);
  import dcmr_pkg::*;

  function automatic q30_t qm(input q30_t a, input q30_t b, input logic half);
    logic signed [63:0] p;
    logic signed [63:0] s;
    p = a * b;
    if (half) begin
      s = (p + 64'sd1073741824) >>> 31;
    end else begin
      s = (p + 64'sd536870912) >>> 30;
    end
    return s[31:0];
  endfunction

  function automatic term_t sx34(input q30_t v);
    return {{2{v[31]}}, v};
  endfunction

  logic       v1, v2, v3;
  q30_t       t1, t2, t5, t6;
  q30_t       ss1, cs1, s2s1, c2s1;
  dcmr_side_t side1, side2, side3;

  q30_t       a2, d2, e2, f2, g2, h2, i2, t3, t4;
  q30_t       ss2, cs2;

  q30_t       a3, b3, c3, d3, e3, f3, g3, h3, i3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1    <= qm(sin_in[ANG_D], cos_in[ANG_R], 1'b0);
      t2    <= qm(sin_in[ANG_D2], sin_in[ANG_R], 1'b0);
      t5    <= qm(cos_in[ANG_D], cos_in[ANG_R], 1'b0);
      t6    <= qm(cos_in[ANG_D2], sin_in[ANG_R], 1'b0);
      ss1   <= sin_in[ANG_S];
      cs1   <= cos_in[ANG_S];
      s2s1  <= sin_in[ANG_S2];
      c2s1  <= cos_in[ANG_S2];
      side1 <= side_in;

      a2    <= qm(t1, s2s1, 1'b0);
      d2    <= qm(t1, c2s1, 1'b0);
      e2    <= qm(t2, s2s1, 1'b1);
      t3    <= qm(t2, ss1, 1'b0);
      t4    <= qm(t2, cs1, 1'b0);
      f2    <= qm(t5, cs1, 1'b0);
      g2    <= qm(t5, ss1, 1'b0);
      h2    <= qm(t6, ss1, 1'b0);
      i2    <= qm(t6, cs1, 1'b0);
      ss2   <= ss1;
      cs2   <= cs1;
      side2 <= side1;

      a3    <= a2;
      b3    <= qm(t3, ss2, 1'b0);
      c3    <= qm(t4, cs2, 1'b0);
      d3    <= d2;
      e3    <= e2;
      f3    <= f2;
      g3    <= g2;
      h3    <= h2;
      i3    <= i2;
      side3 <= side2;

      term[SLOT_XX] <= sx34(a3) - sx34(c3);
      term[SLOT_YY] <= -(sx34(a3) + sx34(b3));
      term[SLOT_ZZ] <= sx34(b3) + sx34(c3);
      term[SLOT_XY] <= sx34(d3) + sx34(e3);
      term[SLOT_XZ] <= sx34(g3) - sx34(i3);
      term[SLOT_YZ] <= sx34(f3) + sx34(h3);
      side_out      <= side3;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dcmr_scale.sv
// Scale each term by area times rate, round half away from zero, saturate.
// Five stages with split 32-bit partial products. Depends on dcmr_pkg.
`default_nettype none

module dcmr_scale (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  dcmr_pkg::term_t      term [dcmr_pkg::NUM_SLOT],
  input  dcmr_pkg::dcmr_side_t side_in,
  output logic                 out_valid,
  output dcmr_pkg::dcmr_beat_t beat
);
  import dcmr_pkg::*;

  localparam logic [95:0] ROUND   = 96'h2000_0000;
  localparam logic [63:0] LIM_POS = {1'b0, {63{1'b1}}};
  localparam logic [63:0] LIM_NEG = {1'b1, 63'd0};

  term_t              neg_term [NUM_SLOT];
  logic signed [63:0] neg_ar;

  logic               v1, v2, v3, v4;
  logic               last1, last2, last3, last4;
  logic [31:0]        amag1 [NUM_SLOT];
  logic [NUM_SLOT-1:0] neg1, neg2, neg3, neg4, sat4;
  logic [62:0]        bmag1;

  logic [63:0]        plo2 [NUM_SLOT];
  logic [62:0]        phi2 [NUM_SLOT];

  logic [95:0]        psum [NUM_SLOT];
  logic [65:0]        mag3 [NUM_SLOT];

  logic [63:0]        lim  [NUM_SLOT];
  logic [63:0]        mag4 [NUM_SLOT];
  logic [63:0]        res  [NUM_SLOT];

  always_comb begin
    for (int k = 0; k < NUM_SLOT; k++) begin
      neg_term[k] = -term[k];
    end
    neg_ar = -side_in.ar;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_SLOT; k++) begin
      psum[k] = {32'd0, plo2[k]} + {1'b0, phi2[k], 32'd0} + ROUND;
      lim[k]  = neg3[k] ? LIM_NEG : LIM_POS;
      res[k]  = neg4[k] ? -mag4[k] : mag4[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NUM_SLOT; k++) begin
        amag1[k] <= term[k][33] ? neg_term[k][31:0] : term[k][31:0];
        neg1[k]  <= term[k][33] ^ side_in.ar[63];

        plo2[k]  <= {32'd0, amag1[k]} * {32'd0, bmag1[31:0]};
        phi2[k]  <= {31'd0, amag1[k]} * {32'd0, bmag1[62:32]};

        mag3[k]  <= psum[k][95:30];

        if (mag3[k] > {2'b00, lim[k]}) begin
          mag4[k] <= lim[k];
          sat4[k] <= 1'b1;
        end else begin
          mag4[k] <= mag3[k][63:0];
          sat4[k] <= 1'b0;
        end
      end
      bmag1 <= side_in.ar[63] ? neg_ar[62:0] : side_in.ar[62:0];
      last1 <= side_in.last;
      neg2  <= neg1;
      last2 <= last1;
      neg3  <= neg2;
      last3 <= last2;
      neg4  <= neg3;
      last4 <= last3;

      beat.m_xx <= res[SLOT_XX];
      beat.m_yy <= res[SLOT_YY];
      beat.m_zz <= res[SLOT_ZZ];
      beat.m_xy <= res[SLOT_XY];
      beat.m_xz <= res[SLOT_XZ];
      beat.m_yz <= res[SLOT_YZ];
      beat.last <= last4;
      beat.sat  <= |sat4;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/double_couple_moment_rate_core.sv
// Top level of the double-couple moment-rate core: config register, pipeline,
// output register with skid stage. Depends on dcmr_pkg and four dcmr_* modules.
//
// Takes one sample beat per clock while in_stall is low and returns one
// moment-rate beat per sample, in order. A sample passes 45 register stages.
// The depth is set mostly by the five-lane CORDIC: an entry register, one
// rotation per stage over 30 stages and an exit register. Add three
// phase-conversion stages, four term-product stages, five scaling stages and
// the output register. The whole pipeline advances together; a one-beat skid
// stage behind the output register absorbs the beat in flight when the
// consumer stalls, and in_stall is that skid stage's full flag.
// Write rake_in_degrees only while no beats are in flight.
`default_nettype none

module double_couple_moment_rate_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [25:0] strike_angle,
  input  logic signed [25:0] dip_angle,
  input  logic signed [25:0] rake_angle,
  input  logic [31:0]        patch_area,
  input  logic signed [31:0] slip_rate,
  input  logic               last_item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] m_xx,
  output logic signed [63:0] m_yy,
  output logic signed [63:0] m_zz,
  output logic signed [63:0] m_xy,
  output logic signed [63:0] m_xz,
  output logic signed [63:0] m_yz,
  output logic               last_out,
  output logic               saturated
);
  import dcmr_pkg::*;

  logic       rake_in_degrees;
  logic       adv;
  logic       skid_valid;

  logic       ph_valid;
  phase_t     phase [NUM_ANG];
  dcmr_side_t ph_side;

  logic       cr_valid;
  q30_t       sin_v [NUM_ANG];
  q30_t       cos_v [NUM_ANG];
  dcmr_side_t cr_side;

  logic       tm_valid;
  term_t      term [NUM_SLOT];
  dcmr_side_t tm_side;

  logic       pipe_valid;
  dcmr_beat_t pipe_beat;
  dcmr_beat_t out_beat;
  dcmr_beat_t skid_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      rake_in_degrees <= 1'b1;
    end else if (cfg_wr_en) begin
      rake_in_degrees <= cfg_wr_data;
    end
  end

  assign adv      = !skid_valid;
  assign in_stall = skid_valid;

  dcmr_phase u_phase (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .in_valid        (in_valid),
    .strike_angle    (strike_angle),
    .dip_angle       (dip_angle),
    .rake_angle      (rake_angle),
    .patch_area      (patch_area),
    .slip_rate       (slip_rate),
    .last_item       (last_item),
    .rake_in_degrees (rake_in_degrees),
    .out_valid       (ph_valid),
    .phase           (phase),
    .side            (ph_side)
  );

  dcmr_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (ph_valid),
    .phase     (phase),
    .side_in   (ph_side),
    .out_valid (cr_valid),
    .sin_out   (sin_v),
    .cos_out   (cos_v),
    .side_out  (cr_side)
  );

  dcmr_terms u_terms (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (cr_valid),
    .sin_in    (sin_v),
    .cos_in    (cos_v),
    .side_in   (cr_side),
    .out_valid (tm_valid),
    .term      (term),
    .side_out  (tm_side)
  );

  dcmr_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (tm_valid),
    .term      (term),
    .side_in   (tm_side),
    .out_valid (pipe_valid),
    .beat      (pipe_beat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_stall) begin
      if (adv && pipe_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= pipe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_stall) begin
      if (adv) begin
        skid_beat <= pipe_beat;
      end
    end else if (skid_valid) begin
      out_beat <= skid_beat;
    end else begin
      out_beat <= pipe_beat;
    end
  end

  assign m_xx      = out_beat.m_xx;
  assign m_yy      = out_beat.m_yy;
  assign m_zz      = out_beat.m_zz;
  assign m_xy      = out_beat.m_xy;
  assign m_xz      = out_beat.m_xz;
  assign m_yz      = out_beat.m_yz;
  assign last_out  = out_beat.last;
  assign saturated = out_beat.sat;

endmodule

`default_nettype wire

FILE: rtl/core/dcmr_check.sv
// Port-level checker for the double-couple moment-rate core, bound to the top.
// Depends on double_couple_moment_rate_core_assert.svh.
`default_nettype none

`include "double_couple_moment_rate_core_assert.svh"

module dcmr_check (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [63:0] m_xx,
  input logic signed [63:0] m_yy,
  input logic signed [63:0] m_zz,
  input logic signed [63:0] m_xy,
  input logic signed [63:0] m_xz,
  input logic signed [63:0] m_yz,
  input logic               saturated
);

  localparam logic signed [63:0] M_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] M_MIN = 64'sh8000_0000_0000_0000;

  logic at_rail;

  assign at_rail = (m_xx == M_MAX) || (m_xx == M_MIN) || (m_yy == M_MAX) ||
                   (m_yy == M_MIN) || (m_zz == M_MAX) || (m_zz == M_MIN) ||
                   (m_xy == M_MAX) || (m_xy == M_MIN) || (m_xz == M_MAX) ||
                   (m_xz == M_MIN) || (m_yz == M_MAX) || (m_yz == M_MIN);

  `DCMR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(m_xx) && $stable(m_yz) && $stable(saturated), "stalled result beat changed")
  `DCMR_ASSERT_SAME(a_stall_has_out, clk, rst, in_stall, out_valid, "input stalled with no result beat waiting")
  `DCMR_ASSERT_NEXT(a_stall_release, clk, rst, in_stall && !out_stall, !in_stall, "input stall held after result beat taken")
  `DCMR_ASSERT_SAME(a_sat_rail, clk, rst, out_valid && saturated, at_rail, "saturation flagged with no term at a rail")

endmodule

bind double_couple_moment_rate_core dcmr_check u_dcmr_check (.*);

`default_nettype wire
